FILE: rtl/core/trs_pkg.sv
// Shared types, constants, rounding and clamping helpers for the model matrix builder.
package trs_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  // Pipeline depths: quarter sine, sine/cosine unit, matrix unit, whole block
  localparam int QS_LAT  = 22;
  localparam int SC_LAT  = QS_LAT + 1;
  localparam int MX_LAT  = 4;
  localparam int TOP_LAT = SC_LAT + MX_LAT;

  // Q30 constants of the quarter-wave series
  localparam logic [30:0] PIHALF_Q30 = 31'd1686629713;
  localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
  localparam logic [61:0] HALF_Q30   = 62'h2000_0000;

  // Horner divisors and their truncated reciprocals (2^32 / d)
  localparam int HORNER_STEPS = 6;
  localparam logic [7:0] HDIV_D [HORNER_STEPS] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
  localparam logic [29:0] HDIV_M [HORNER_STEPS] = '{
    30'((64'd1 << 32) / 64'd156), 30'((64'd1 << 32) / 64'd110),
    30'((64'd1 << 32) / 64'd72),  30'((64'd1 << 32) / 64'd42),
    30'((64'd1 << 32) / 64'd20),  30'((64'd1 << 32) / 64'd6)
  };

  localparam logic signed [23:0] OUT_MAX = 24'sh7F_FFFF;
  localparam logic signed [23:0] OUT_MIN = -24'sh80_0000;

  typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

  typedef struct packed {
    logic signed [31:0] translate_x;
    logic signed [31:0] translate_y;
    logic signed [31:0] translate_z;
    logic [15:0]        angle_x;
    logic [15:0]        angle_y;
    logic [15:0]        angle_z;
    logic signed [23:0] scale_x;
    logic signed [23:0] scale_y;
    logic signed [23:0] scale_z;
  } item_t;

  typedef struct packed {
    logic signed [23:0] m00;
    logic signed [23:0] m01;
    logic signed [23:0] m02;
    logic signed [31:0] m03;
    logic signed [23:0] m10;
    logic signed [23:0] m11;
    logic signed [23:0] m12;
    logic signed [31:0] m13;
    logic signed [23:0] m20;
    logic signed [23:0] m21;
    logic signed [23:0] m22;
    logic signed [31:0] m23;
  } result_t;

  // Round-to-nearest right shift, half away from zero
  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v,
                                                 input int unsigned n);
    logic signed [63:0] half;
    half = 64'sd1 <<< (n - 1);
    if (v >= 0) begin
      return (v + half) >>> n;
    end
    return -((-v + half) >>> n);
  endfunction

  // Clamp to the signed Q8.16 output range
  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    if (v > 64'(OUT_MAX)) begin
      return OUT_MAX;
    end
    if (v < 64'(OUT_MIN)) begin
      return OUT_MIN;
    end
    return v[23:0];
  endfunction

endpackage

FILE: rtl/core/trs_model_matrix_builder_top.sv
// Top level of the model matrix builder: T*Rz*Ry*Rx*S, top three rows.
//
//   channel   ports                 transfer when          payload
//   command   start, busy, item     start & !busy at clk   item_t
//   result    done, result          done at clk            result_t
//
// One item may be taken every cycle; each result follows its item through the
// 22-stage quarter-sine pipeline, one sign stage and the four-stage matrix
// unit. Synchronous reset clears all valid bits; busy is high only during
// reset. The receiver cannot stall, so nothing in the pipeline ever waits.
module trs_model_matrix_builder_top import trs_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    done,
  output result_t result
);

  logic vin;

  assign busy = rst;
  assign vin  = start & ~busy;

  // Hold translation and scale beside the trig pipelines
  item_t dly [SC_LAT];

  always_ff @(posedge clk) begin
    dly[0] <= item;
    for (int i = 1; i < SC_LAT; i++) begin
      dly[i] <= dly[i-1];
    end
  end

  logic                        vx, vy, vz;
  logic signed [FRAC_BITS+1:0] sx, cx, sy, cy, sz, cz;

  trs_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_sc_x (
    .clk(clk), .rst(rst), .vin(vin), .angle(ANGLE_BITS'(item.angle_x)),
    .vout(vx), .sn(sx), .cs(cx)
  );

  trs_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_sc_y (
    .clk(clk), .rst(rst), .vin(vin), .angle(ANGLE_BITS'(item.angle_y)),
    .vout(vy), .sn(sy), .cs(cy)
  );

  trs_sincos #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_sc_z (
    .clk(clk), .rst(rst), .vin(vin), .angle(ANGLE_BITS'(item.angle_z)),
    .vout(vz), .sn(sz), .cs(cz)
  );

  trs_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
    .clk(clk), .rst(rst), .vin(vx & vy & vz), .item(dly[SC_LAT-1]),
    .sx(sx), .cx(cx), .sy(sy), .cy(cy), .sz(sz), .cz(cz),
    .vout(done), .result(result)
  );

  // A result only ever follows an accepted command by the fixed latency
  a_done_follows_cmd: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, TOP_LAT))
    else $error("result without matching command transfer");

  // Translation column entries m03 and m23 carry the command's translation unchanged
  a_translation_kept: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.m03 == $past(item.translate_x, TOP_LAT)) &&
             (result.m23 == $past(item.translate_z, TOP_LAT)))
    else $error("translation column does not match command");

  // Reset drops every item in flight
  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !done)
    else $error("result strobe right after reset");

endmodule

FILE: rtl/core/trs_qsine.sv
// Pipelined quarter-wave sine: odd series in Horner form, at most one multiply per stage.
module trs_qsine import trs_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  vin,
  input  logic [ANGLE_BITS-2:0] u,
  output logic                  vout,
  output logic [FRAC_BITS:0]    sine
);

  localparam int QB = ANGLE_BITS - 2;
  localparam int XW = QB + 31;
  localparam logic [FRAC_BITS:0] ONE_F = {1'b1, {FRAC_BITS{1'b0}}};

  typedef struct packed {
    logic        z;
    logic        f;
    logic [30:0] x;
    logic [31:0] x2;
  } side_t;

  // Scale the quarter-wave step to radians in Q30
  logic [XW-1:0] xprod;
  logic          s0_v;
  logic          s0_z;
  logic          s0_f;
  logic [30:0]   s0_x;

  assign xprod = XW'(u[QB-1:0]) * XW'(PIHALF_Q30) + (XW'(1) << (QB - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else begin
      s0_v <= vin;
    end
    s0_z <= (u == '0);
    s0_f <= u[QB];
    s0_x <= xprod[QB+30:QB];
  end

  // Square the argument and open the Horner chain
  logic        h_v    [HORNER_STEPS+1];
  side_t       h_side [HORNER_STEPS+1];
  logic [30:0] h_t    [HORNER_STEPS+1];
  logic [61:0] x2prod;

  assign x2prod = 62'(s0_x) * 62'(s0_x) + HALF_Q30;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_v[0] <= 1'b0;
    end else begin
      h_v[0] <= s0_v;
    end
    h_side[0] <= '{z: s0_z, f: s0_f, x: s0_x, x2: x2prod[61:30]};
    h_t[0]    <= ONE_Q30;
  end

  // Each Horner step: multiply, reciprocal divide, correct and subtract
  for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_step
    logic        a_v;
    logic        b_v;
    side_t       a_s;
    side_t       b_s;
    logic [31:0] a_y;
    logic [31:0] b_y;
    logic [29:0] b_q0;
    logic [62:0] yprod;
    logic [61:0] qprod;
    logic [37:0] dprod;
    logic [32:0] rem;
    logic [29:0] q;

    assign yprod = 63'(h_side[k].x2) * 63'(h_t[k]) + 63'(HALF_Q30);
    assign qprod = 62'(a_y) * 62'(HDIV_M[k]);
    assign dprod = 38'(b_q0) * 38'(HDIV_D[k]);
    assign rem   = 33'(b_y) - 33'(dprod);
    assign q     = b_q0 + 30'(rem >= 33'(HDIV_D[k]));

    always_ff @(posedge clk) begin
      if (rst) begin
        a_v      <= 1'b0;
        b_v      <= 1'b0;
        h_v[k+1] <= 1'b0;
      end else begin
        a_v      <= h_v[k];
        b_v      <= a_v;
        h_v[k+1] <= b_v;
      end
      a_y         <= yprod[61:30];
      a_s         <= h_side[k];
      b_q0        <= qprod[61:32];
      b_y         <= a_y;
      b_s         <= a_s;
      h_t[k+1]    <= ONE_Q30 - 31'(q);
      h_side[k+1] <= b_s;
    end
  end

  // Final product with the argument
  logic [61:0] sprod;
  logic        f1_v;
  logic        f1_z;
  logic        f1_f;
  logic [31:0] f1_s;

  assign sprod = 62'(h_side[HORNER_STEPS].x) * 62'(h_t[HORNER_STEPS]) + HALF_Q30;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
    end else begin
      f1_v <= h_v[HORNER_STEPS];
    end
    f1_z <= h_side[HORNER_STEPS].z;
    f1_f <= h_side[HORNER_STEPS].f;
    f1_s <= sprod[61:30];
  end

  // Round to output precision, clamp to one, apply end points
  logic [31:0]        s2;
  logic [FRAC_BITS:0] sine_next;

  assign s2 = (f1_s + (32'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);

  always_comb begin
    if (f1_z) begin
      sine_next = '0;
    end else if (f1_f || (s2 > 32'(ONE_F))) begin
      sine_next = ONE_F;
    end else begin
      sine_next = s2[FRAC_BITS:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else begin
      vout <= f1_v;
    end
    sine <= sine_next;
  end

endmodule

FILE: rtl/core/trs_sincos.sv
// Sine and cosine of a binary angle from two quarter-wave sine pipelines.
module trs_sincos import trs_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        vin,
  input  logic [ANGLE_BITS-1:0]       angle,
  output logic                        vout,
  output logic signed [FRAC_BITS+1:0] sn,
  output logic signed [FRAC_BITS+1:0] cs
);

  localparam int QB = ANGLE_BITS - 2;

  // Split into quadrant and remainder; cosine reads the mirrored remainder
  logic [QB:0] u_s;
  logic [QB:0] u_c;

  assign u_s = {1'b0, angle[QB-1:0]};
  assign u_c = {1'b1, {QB{1'b0}}} - u_s;

  // Hold the quadrant alongside the sine pipelines
  quad_t qd [QS_LAT];

  always_ff @(posedge clk) begin
    qd[0] <= quad_t'(angle[ANGLE_BITS-1:ANGLE_BITS-2]);
    for (int i = 1; i < QS_LAT; i++) begin
      qd[i] <= qd[i-1];
    end
  end

  logic                 vs;
  logic                 vc;
  logic [FRAC_BITS:0]   sr;
  logic [FRAC_BITS:0]   sc;

  trs_qsine #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_sin (
    .clk(clk), .rst(rst), .vin(vin), .u(u_s), .vout(vs), .sine(sr)
  );

  trs_qsine #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_cos (
    .clk(clk), .rst(rst), .vin(vin), .u(u_c), .vout(vc), .sine(sc)
  );

  // Apply quadrant signs
  logic signed [FRAC_BITS+1:0] psr;
  logic signed [FRAC_BITS+1:0] psc;
  logic signed [FRAC_BITS+1:0] sn_next;
  logic signed [FRAC_BITS+1:0] cs_next;

  assign psr = signed'({1'b0, sr});
  assign psc = signed'({1'b0, sc});

  always_comb begin
    case (qd[QS_LAT-1])
      QUAD_0: begin
        sn_next = psr;
        cs_next = psc;
      end
      QUAD_1: begin
        sn_next = psc;
        cs_next = -psr;
      end
      QUAD_2: begin
        sn_next = -psr;
        cs_next = -psc;
      end
      default: begin
        sn_next = -psc;
        cs_next = psr;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else begin
      vout <= vs & vc;
    end
    sn <= sn_next;
    cs <= cs_next;
  end

endmodule

FILE: rtl/core/trs_matrix.sv
// Rotation product Rz*Ry*Rx, column scaling and saturation, four stages.
module trs_matrix import trs_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        vin,
  input  item_t                       item,
  input  logic signed [FRAC_BITS+1:0] sx,
  input  logic signed [FRAC_BITS+1:0] cx,
  input  logic signed [FRAC_BITS+1:0] sy,
  input  logic signed [FRAC_BITS+1:0] cy,
  input  logic signed [FRAC_BITS+1:0] sz,
  input  logic signed [FRAC_BITS+1:0] cz,
  output logic                        vout,
  output result_t                     result
);

  localparam int W  = FRAC_BITS + 2;
  localparam int RW = W + 1;
  localparam int PW = RW + 24;

  function automatic logic signed [W-1:0] fmul(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [2*W-1:0] p;
    p = a * b;
    return W'(rnd_shr(64'(p), FRAC_BITS));
  endfunction

  // Stage 0: pairwise trig products
  logic                m0_v;
  item_t               m0_item;
  logic signed [W-1:0] czcy, czsy, szcx, szsx, szsy, czcx, czsx, szcy, cysx, cycx;
  logic signed [W-1:0] m0_sx, m0_cx, m0_sy;

  always_ff @(posedge clk) begin
    if (rst) begin
      m0_v <= 1'b0;
    end else begin
      m0_v <= vin;
    end
    m0_item <= item;
    czcy    <= fmul(cz, cy);
    czsy    <= fmul(cz, sy);
    szcx    <= fmul(sz, cx);
    szsx    <= fmul(sz, sx);
    szsy    <= fmul(sz, sy);
    czcx    <= fmul(cz, cx);
    czsx    <= fmul(cz, sx);
    szcy    <= fmul(sz, cy);
    cysx    <= fmul(cy, sx);
    cycx    <= fmul(cy, cx);
    m0_sx   <= sx;
    m0_cx   <= cx;
    m0_sy   <= sy;
  end

  // Stage 1: third factor and sums
  logic                 m1_v;
  item_t                m1_item;
  logic signed [RW-1:0] r [9];

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_v <= 1'b0;
    end else begin
      m1_v <= m0_v;
    end
    m1_item <= m0_item;
    r[0]    <= RW'(czcy);
    r[1]    <= RW'(fmul(czsy, m0_sx)) - RW'(szcx);
    r[2]    <= RW'(fmul(czsy, m0_cx)) + RW'(szsx);
    r[3]    <= RW'(szcy);
    r[4]    <= RW'(fmul(szsy, m0_sx)) + RW'(czcx);
    r[5]    <= RW'(fmul(szsy, m0_cx)) - RW'(czsx);
    r[6]    <= -RW'(m0_sy);
    r[7]    <= RW'(cysx);
    r[8]    <= RW'(cycx);
  end

  // Stage 2: scale each column
  logic signed [23:0]   scl [3];
  logic                 m2_v;
  item_t                m2_item;
  logic signed [PW-1:0] pr [9];

  assign scl[0] = m1_item.scale_x;
  assign scl[1] = m1_item.scale_y;
  assign scl[2] = m1_item.scale_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_v <= 1'b0;
    end else begin
      m2_v <= m1_v;
    end
    m2_item <= m1_item;
    for (int i = 0; i < 9; i++) begin
      pr[i] <= PW'(r[i]) * PW'(scl[i % 3]);
    end
  end

  // Stage 3: round, saturate and pass the translation through
  logic signed [23:0] e [9];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      e[i] = sat24(rnd_shr(64'(pr[i]), FRAC_BITS));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else begin
      vout <= m2_v;
    end
    result.m00 <= e[0];
    result.m01 <= e[1];
    result.m02 <= e[2];
    result.m03 <= m2_item.translate_x;
    result.m10 <= e[3];
    result.m11 <= e[4];
    result.m12 <= e[5];
    result.m13 <= m2_item.translate_y;
    result.m20 <= e[6];
    result.m21 <= e[7];
    result.m22 <= e[8];
    result.m23 <= m2_item.translate_z;
  end

endmodule

FILE: tb/trs_model_matrix_checker.sv
// Checker for the model matrix builder: predicts each result and compares it.
module trs_model_matrix_checker import trs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    busy,
  input  item_t   item,
  input  logic    done,
  input  result_t result,
  output int      fail_count,
  output int      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ABITS = 16;
  localparam int FBITS = 16;

  result_t matrix_q[$];

  function automatic longint round_shift(longint v, int n);
    longint half;
    half = longint'(1) <<< (n - 1);
    if (v >= 0) begin
      return (v + half) >>> n;
    end
    return -((-v + half) >>> n);
  endfunction

  function automatic longint qmul(longint a, longint b);
    return round_shift(a * b, FBITS);
  endfunction

  // Quarter-wave sine in Q1.FBITS, series to x^13
  function automatic longint qsine(longint unsigned u);
    longint unsigned x, x2, t, s;
    longint unsigned divs [6];
    divs = '{156, 110, 72, 42, 20, 6};
    if (u == 0) begin
      return 0;
    end
    if (u >= (64'd1 << (ABITS - 2))) begin
      return longint'(1) << FBITS;
    end
    x = (u * 64'd1686629713 + (64'd1 << (ABITS - 3))) >> (ABITS - 2);
    x2 = (x * x + (64'd1 << 29)) >> 30;
    t = 64'd1 << 30;
    for (int i = 0; i < 6; i++) begin
      t = (64'd1 << 30) - ((x2 * t + (64'd1 << 29)) >> 30) / divs[i];
    end
    s = (x * t + (64'd1 << 29)) >> 30;
    s = (s + (64'd1 << (29 - FBITS))) >> (30 - FBITS);
    if (s > (64'd1 << FBITS)) begin
      s = 64'd1 << FBITS;
    end
    return longint'(s);
  endfunction

  function automatic void angle_sincos(input logic [15:0] a, output longint sn,
                                       output longint cs);
    longint unsigned q, r;
    longint sr, sc;
    quad_t quad;
    q = 64'd1 << (ABITS - 2);
    quad = quad_t'(a[15:14]);
    r = a[13:0];
    sr = qsine(r);
    sc = qsine(q - r);
    case (quad)
      QUAD_0: begin sn = sr;  cs = sc;  end
      QUAD_1: begin sn = sc;  cs = -sr; end
      QUAD_2: begin sn = -sr; cs = -sc; end
      default: begin sn = -sc; cs = sr; end
    endcase
  endfunction

  function automatic logic signed [23:0] scale_entry(longint r, longint scl);
    longint v;
    v = round_shift(r * scl, FBITS);
    if (v > 8388607) begin
      v = 8388607;
    end
    if (v < -8388608) begin
      v = -8388608;
    end
    return v[23:0];
  endfunction

  function automatic result_t build_matrix(item_t it);
    longint sx, cx, sy, cy, sz, cz, kx, ky, kz;
    longint r [9];
    result_t m;
    angle_sincos(it.angle_x, sx, cx);
    angle_sincos(it.angle_y, sy, cy);
    angle_sincos(it.angle_z, sz, cz);
    kx = it.scale_x;
    ky = it.scale_y;
    kz = it.scale_z;
    r[0] = qmul(cz, cy);
    r[1] = qmul(qmul(cz, sy), sx) - qmul(sz, cx);
    r[2] = qmul(qmul(cz, sy), cx) + qmul(sz, sx);
    r[3] = qmul(sz, cy);
    r[4] = qmul(qmul(sz, sy), sx) + qmul(cz, cx);
    r[5] = qmul(qmul(sz, sy), cx) - qmul(cz, sx);
    r[6] = -sy;
    r[7] = qmul(cy, sx);
    r[8] = qmul(cy, cx);
    m.m00 = scale_entry(r[0], kx);
    m.m01 = scale_entry(r[1], ky);
    m.m02 = scale_entry(r[2], kz);
    m.m03 = it.translate_x;
    m.m10 = scale_entry(r[3], kx);
    m.m11 = scale_entry(r[4], ky);
    m.m12 = scale_entry(r[5], kz);
    m.m13 = it.translate_y;
    m.m20 = scale_entry(r[6], kx);
    m.m21 = scale_entry(r[7], ky);
    m.m22 = scale_entry(r[8], kz);
    m.m23 = it.translate_z;
    return m;
  endfunction

  function automatic int field_diff(string nm, longint e, longint a);
    if (e != a) begin
      $display("%0t mismatch %s expected %0d actual %0d", $time, nm, e, a);
      return 1;
    end
    return 0;
  endfunction

  assign pending = matrix_q.size();

  // Predict on each command transfer, compare on each result transfer
  always @(posedge clk) begin
    result_t e;
    int bad;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (start && !busy) begin
        matrix_q.push_back(build_matrix(item));
      end
      if (done) begin
        if (matrix_q.size() == 0) begin
          $display("%0t unexpected result %h", $time, result);
          fail_count <= fail_count + 1;
        end else begin
          e = matrix_q.pop_front();
          bad = 0;
          bad += field_diff("m00", e.m00, result.m00);
          bad += field_diff("m01", e.m01, result.m01);
          bad += field_diff("m02", e.m02, result.m02);
          bad += field_diff("m03", e.m03, result.m03);
          bad += field_diff("m10", e.m10, result.m10);
          bad += field_diff("m11", e.m11, result.m11);
          bad += field_diff("m12", e.m12, result.m12);
          bad += field_diff("m13", e.m13, result.m13);
          bad += field_diff("m20", e.m20, result.m20);
          bad += field_diff("m21", e.m21, result.m21);
          bad += field_diff("m22", e.m22, result.m22);
          bad += field_diff("m23", e.m23, result.m23);
          if (bad != 0) begin
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

FILE: tb/tb_trs_model_matrix_builder_top.sv
// Testbench top: drives command transfers into the builder and gives the verdict.
module tb_trs_model_matrix_builder_top import trs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCH_LIMIT = 2000;

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  item_t   item;
  logic    done;
  result_t result;
  int      fail_count;
  int      pending;
  int      quiet;

  trs_model_matrix_builder_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .item(item), .done(done), .result(result)
  );

  trs_model_matrix_checker u_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
  end
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: count cycles without any transfer
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCH_LIMIT) begin
        $display("FAIL trs_model_matrix_builder_top");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 7))
      0: return 16'($urandom_range(0, 3)) << 14;
      1: return (16'($urandom_range(0, 3)) << 14) + 16'($urandom_range(0, 3));
      2: return (16'($urandom_range(1, 4)) << 14) - 16'($urandom_range(1, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick_scale();
    case ($urandom_range(0, 7))
      0: return 24'h80_0000;
      1: return 24'h7F_FFFF;
      2: return 24'h01_0000;
      3: return 24'hFF_0000;
      4: return 24'h0;
      5: return 24'($signed($urandom_range(0, 131072)) - 65536);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic item_t random_item();
    item_t it;
    it.translate_x = pick32();
    it.translate_y = pick32();
    it.translate_z = pick32();
    it.angle_x = pick_angle();
    it.angle_y = pick_angle();
    it.angle_z = pick_angle();
    it.scale_x = pick_scale();
    it.scale_y = pick_scale();
    it.scale_z = pick_scale();
    return it;
  endfunction

  // Hold start until the transfer happens, with random idle before it
  task automatic send(input item_t it, input int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    item_t it;
    start = 1'b0;
    item = '0;
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end

    // Directed: quadrant edges, extreme scales and translations, all ones/zeros
    for (int i = 0; i < 24; i++) begin
      it.translate_x = (i & 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      it.translate_y = (i & 2) ? 32'hFFFF_FFFF : 32'h0;
      it.translate_z = 32'(i) << 16;
      it.angle_x = 16'(i % 4) << 14;
      it.angle_y = (16'((i / 4) % 4) << 14) + ((i & 1) ? 16'h0001 : 16'h0000);
      it.angle_z = (i > 15) ? 16'hFFFF : (16'(i % 8) << 13);
      it.scale_x = (i & 1) ? 24'h7F_FFFF : 24'h80_0000;
      it.scale_y = (i & 4) ? 24'h01_0000 : 24'hFF_FFFF;
      it.scale_z = (i & 8) ? 24'h80_0000 : 24'h0;
      send(it, 0);
    end
    drain();

    for (int i = 0; i < 180; i++) begin
      send(random_item(), 33);
    end
    // Pause until every result is back
    drain();
    for (int i = 0; i < 180; i++) begin
      send(random_item(), 81);
    end
    for (int i = 0; i < 190; i++) begin
      send(random_item(), 0);
    end
    drain();
    repeat (TOP_LAT + 10) @(posedge clk);

    if (fail_count == 0) begin
      $display("PASS trs_model_matrix_builder_top");
    end else begin
      $display("FAIL trs_model_matrix_builder_top");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/core/trs_pkg.sv
rtl/core/trs_qsine.sv
rtl/core/trs_sincos.sv
rtl/core/trs_matrix.sv
rtl/core/trs_model_matrix_builder_top.sv
tb/trs_model_matrix_checker.sv
tb/tb_trs_model_matrix_builder_top.sv
